// ===== rtl/rdsc_pkg.sv =====
// Shared constants and the digit-to-ASCII function for the radix digit string converter.
// No dependencies; used by rdsc_divider and radix_digit_string_converter_unit.
package rdsc_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 31;
    localparam int RADIX_WIDTH         = 6;
    localparam int CHAR_WIDTH          = 7;

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] DIGIT_TEN   = 6'd10;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_WIDTH-1:0] ASCII_ALPHA = 7'd65;

    function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [RADIX_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] wide_d;
        wide_d = {1'b0, d};
        if (d >= DIGIT_TEN)
        begin
            return wide_d - {1'b0, DIGIT_TEN} + ASCII_ALPHA;
        end
        return wide_d + ASCII_ZERO;
    endfunction

endpackage

// ===== rtl/rdsc_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on rdsc_pkg for the radix width and the default value width.
module rdsc_divider #(
    parameter int VALUE_WIDTH = rdsc_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [VALUE_WIDTH-1:0]           dividend,
    input  logic [rdsc_pkg::RADIX_WIDTH-1:0] divisor,
    output logic                             done,
    output logic [VALUE_WIDTH-1:0]           quotient,
    output logic [rdsc_pkg::RADIX_WIDTH-1:0] remainder
);

    localparam int RW = rdsc_pkg::RADIX_WIDTH;
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [RW-1:0]          r_reg, r_next;
    logic [RW:0]            trial;
    logic [RW:0]            diff;
    logic                   fits;

    always_comb
    begin
        trial     = {r_reg, q_reg[VALUE_WIDTH-1]};
        diff      = trial - {1'b0, divisor};
        fits      = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        if (busy_reg)
        begin
            q_next   = {q_reg[VALUE_WIDTH-2:0], fits};
            r_next   = fits ? diff[RW-1:0] : trial[RW-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(VALUE_WIDTH);
            q_next    = dividend;
            r_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// ===== rtl/radix_digit_string_converter_unit.sv =====
// Top level of the radix digit string converter: sequencer, digit store and output register.
// Depends on rdsc_pkg and rdsc_divider.
//
// Each accepted value is divided repeatedly by the radix register in one shared bit-serial
// divider, one division per digit. The digit values are kept in a small memory and then read
// back most significant first; each digit is read, loaded into the output register and held
// there while digit_stall is high. value_stall stays high from the transfer of a value until
// its last digit has been transferred out. A radix outside 2 to 36 gives a single result
// with bad_radix set, in the cycle after the transfer.
module radix_digit_string_converter_unit #(
    parameter int VALUE_WIDTH = rdsc_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             radix_wen,
    input  logic [rdsc_pkg::RADIX_WIDTH-1:0] radix_wdata,
    input  logic                             value_valid,
    output logic                             value_stall,
    input  logic [VALUE_WIDTH-1:0]           value,
    output logic                             digit_valid,
    input  logic                             digit_stall,
    output logic [rdsc_pkg::CHAR_WIDTH-1:0]  digit_char,
    output logic                             last_digit,
    output logic                             bad_radix
);

    localparam int RW    = rdsc_pkg::RADIX_WIDTH;
    localparam int CHW   = rdsc_pkg::CHAR_WIDTH;
    localparam int DEPTH = VALUE_WIDTH + 1;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DSTART = 3'd1;
    localparam logic [2:0] ST_DWAIT  = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;
    localparam logic [2:0] ST_WAIT   = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [RW-1:0]          radix_reg;
    logic [VALUE_WIDTH-1:0] quotient_reg, quotient_next;
    logic [AW-1:0]          digit_count_reg, digit_count_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHW-1:0]         char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   bad_reg, bad_next;
    logic [RW-1:0]          rd_data_reg;
    logic [RW-1:0]          digit_store [DEPTH];

    logic                   radix_bad;
    logic                   store_we;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [RW-1:0]          div_rem;

    rdsc_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (quotient_reg),
        .divisor  (radix_reg),
        .done     (div_done),
        .quotient (div_quot),
        .remainder(div_rem)
    );

    assign radix_bad = (radix_reg < rdsc_pkg::RADIX_MIN) || (radix_reg > rdsc_pkg::RADIX_MAX);

    always_comb
    begin
        state_next       = state_reg;
        quotient_next    = quotient_reg;
        digit_count_next = digit_count_reg;
        idx_next         = idx_reg;
        out_valid_next   = out_valid_reg;
        char_next        = char_reg;
        last_next        = last_reg;
        bad_next         = bad_reg;
        store_we         = 1'b0;
        div_start        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (value_valid)
                begin
                    if (radix_bad)
                    begin
                        char_next      = '0;
                        last_next      = 1'b1;
                        bad_next       = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_WAIT;
                    end
                    else
                    begin
                        quotient_next    = value;
                        digit_count_next = '0;
                        state_next       = ST_DSTART;
                    end
                end
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    store_we         = 1'b1;
                    quotient_next    = div_quot;
                    digit_count_next = digit_count_reg + AW'(1);
                    idx_next         = digit_count_reg;
                    state_next       = (div_quot == '0) ? ST_READ : ST_DSTART;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                char_next      = rdsc_pkg::digit_to_ascii(rd_data_reg);
                last_next      = (idx_reg == '0);
                bad_next       = 1'b0;
                out_valid_next = 1'b1;
                state_next     = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!digit_stall)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - AW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            radix_reg       <= rdsc_pkg::RADIX_RESET;
            quotient_reg    <= '0;
            digit_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            quotient_reg    <= quotient_next;
            digit_count_reg <= digit_count_next;
            out_valid_reg   <= out_valid_next;
            if (radix_wen)
            begin
                radix_reg <= radix_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            digit_store[digit_count_reg] <= div_rem;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= digit_store[idx_reg];
        end
    end

    assign value_stall = (state_reg != ST_IDLE);
    assign digit_valid = out_valid_reg;
    assign digit_char  = char_reg;
    assign last_digit  = last_reg;
    assign bad_radix   = bad_reg;

`ifndef ASSERT_OFF
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && !value_stall |=> value_stall)
        else $error("Converter accepted a value without going busy.");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && bad_radix |-> last_digit && (digit_char == '0))
        else $error("Error result is not a single zero result.");

    a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DWAIT)
        else $error("Divider finished outside the wait state.");

    a_idle_output_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !digit_valid)
        else $error("Result pending while the converter is idle.");
`endif

endmodule
